>>> hw/rtl/pab_pkg.sv
// shared types and widths for the polygon area and bounds block
`timescale 1ns / 1ps

package pab_pkg;

  localparam int COORD_W = 24;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int TERM_W  = PROD_W + 2;
  localparam int SUM_W   = 57;
  localparam int AREA_W  = 56;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one vertex request
  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } in_req_t;

  // one polygon result
  typedef struct packed {
    logic [AREA_W-1:0] area;
    coord_t            min_x;
    coord_t            max_x;
    coord_t            min_y;
    coord_t            max_y;
  } out_res_t;

  // per-stage control: slot holds a vertex, first and last of its polygon
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } stg_ctl_t;

  // bounding box carried between stages
  typedef struct packed {
    coord_t lo_x;
    coord_t hi_x;
    coord_t lo_y;
    coord_t hi_y;
  } box_t;

endpackage

>>> hw/rtl/polygon_area_and_bounds_top.sv
// top level: shoelace polygon area and bounding box, one vertex per cycle
// a result passes the input, product, edge term, sum and result registers after its last vertex request is accepted
// throughput: one vertex request per cycle while no result is held back by out_stall
// the whole pipeline holds only while a result waits under out_stall
// reset: synchronous active-low rst_n empties the pipeline and starts a new polygon
`timescale 1ns / 1ps

module polygon_area_and_bounds_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pab_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output pab_pkg::out_res_t  out_res
);
  import pab_pkg::*;

  // pipeline advance: everything moves unless a result is held back
  logic en;

  // polygon tracking state at the input
  logic   have_first_r;
  coord_t first_x_r, first_y_r;
  coord_t prev_x_r, prev_y_r;

  // input register stage
  stg_ctl_t a_ctl_r;
  coord_t   a_x_r, a_y_r, a_px_r, a_py_r, a_fx_r, a_fy_r;

  // between stages
  stg_ctl_t                  c_ctl;
  coord_t                    c_x, c_y;
  logic signed [TERM_W-1:0]  c_term;
  logic                      d_valid;
  logic [SUM_W-1:0]          d_sum;
  box_t                      d_box;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // polygon state: have_first clears after the last vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      a_ctl_r      <= '0;
    end else if (en) begin
      a_ctl_r.valid <= in_valid;
      a_ctl_r.first <= !have_first_r;
      a_ctl_r.last  <= in_req.last_vertex;
      if (in_valid) begin
        have_first_r <= !in_req.last_vertex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      a_x_r <= in_req.vertex_x;
      a_y_r <= in_req.vertex_y;
      if (have_first_r) begin
        a_px_r <= prev_x_r;
        a_py_r <= prev_y_r;
        a_fx_r <= first_x_r;
        a_fy_r <= first_y_r;
      end else begin
        // first vertex: prev equals current so the edge term is zero,
        // and a single-vertex polygon closes onto itself with zero area
        a_px_r    <= in_req.vertex_x;
        a_py_r    <= in_req.vertex_y;
        a_fx_r    <= in_req.vertex_x;
        a_fy_r    <= in_req.vertex_y;
        first_x_r <= in_req.vertex_x;
        first_y_r <= in_req.vertex_y;
      end
      prev_x_r <= in_req.vertex_x;
      prev_y_r <= in_req.vertex_y;
    end
  end

  // products and edge term
  pab_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .a_ctl  (a_ctl_r),
    .a_x    (a_x_r),
    .a_y    (a_y_r),
    .a_px   (a_px_r),
    .a_py   (a_py_r),
    .a_fx   (a_fx_r),
    .a_fy   (a_fy_r),
    .c_ctl  (c_ctl),
    .c_x    (c_x),
    .c_y    (c_y),
    .c_term (c_term)
  );

  // running sum and box
  pab_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .c_ctl   (c_ctl),
    .c_x     (c_x),
    .c_y     (c_y),
    .c_term  (c_term),
    .d_valid (d_valid),
    .d_sum   (d_sum),
    .d_box   (d_box)
  );

  // area magnitude and result register
  pab_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .d_valid   (d_valid),
    .d_sum     (d_sum),
    .d_box     (d_box),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> hw/rtl/pab_mult.sv
// cross product stages: four products, then the combined edge term
`timescale 1ns / 1ps

module pab_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  pab_pkg::stg_ctl_t a_ctl,
  input  pab_pkg::coord_t   a_x,
  input  pab_pkg::coord_t   a_y,
  input  pab_pkg::coord_t   a_px,
  input  pab_pkg::coord_t   a_py,
  input  pab_pkg::coord_t   a_fx,
  input  pab_pkg::coord_t   a_fy,
  output pab_pkg::stg_ctl_t c_ctl,
  output pab_pkg::coord_t   c_x,
  output pab_pkg::coord_t   c_y,
  output logic signed [pab_pkg::TERM_W-1:0] c_term
);
  import pab_pkg::*;

  stg_ctl_t                  b_ctl_r;
  coord_t                    b_x_r, b_y_r;
  logic signed [PROD_W-1:0]  b_p1_r, b_p2_r, b_p3_r, b_p4_r;
  logic signed [PROD_W-1:0]  p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  stg_ctl_t                  c_ctl_r;
  coord_t                    c_x_r, c_y_r;
  logic signed [TERM_W-1:0]  c_term_r, term_nxt, close_nxt;

  // edge term prev_y*x - prev_x*y, closing term y*first_x - x*first_y
  always_comb begin
    p1_nxt = a_py * a_x;
    p2_nxt = a_px * a_y;
    p3_nxt = a_y * a_fx;
    p4_nxt = a_x * a_fy;
  end

  always_comb begin
    close_nxt = b_ctl_r.last ? (TERM_W'(b_p3_r) - TERM_W'(b_p4_r)) : '0;
    term_nxt  = TERM_W'(b_p1_r) - TERM_W'(b_p2_r) + close_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else if (en) begin
      b_ctl_r <= a_ctl;
      c_ctl_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x_r    <= a_x;
      b_y_r    <= a_y;
      b_p1_r   <= p1_nxt;
      b_p2_r   <= p2_nxt;
      b_p3_r   <= p3_nxt;
      b_p4_r   <= p4_nxt;
      c_x_r    <= b_x_r;
      c_y_r    <= b_y_r;
      c_term_r <= term_nxt;
    end
  end

  assign c_ctl  = c_ctl_r;
  assign c_x    = c_x_r;
  assign c_y    = c_y_r;
  assign c_term = c_term_r;

endmodule

>>> hw/rtl/pab_accum.sv
// running shoelace sum and bounding box of the current polygon
`timescale 1ns / 1ps

module pab_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  pab_pkg::stg_ctl_t c_ctl,
  input  pab_pkg::coord_t   c_x,
  input  pab_pkg::coord_t   c_y,
  input  logic signed [pab_pkg::TERM_W-1:0] c_term,
  output logic              d_valid,
  output logic [pab_pkg::SUM_W-1:0] d_sum,
  output pab_pkg::box_t     d_box
);
  import pab_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  box_t             box_r, box_nxt;
  logic             d_valid_r;
  logic [SUM_W-1:0] d_sum_r;
  box_t             d_box_r;

  always_comb begin
    sum_nxt = sum_r + SUM_W'(c_term);
    if (c_ctl.first) begin
      box_nxt = '{lo_x: c_x, hi_x: c_x, lo_y: c_y, hi_y: c_y};
    end else begin
      box_nxt.lo_x = (c_x < box_r.lo_x) ? c_x : box_r.lo_x;
      box_nxt.hi_x = (c_x > box_r.hi_x) ? c_x : box_r.hi_x;
      box_nxt.lo_y = (c_y < box_r.lo_y) ? c_y : box_r.lo_y;
      box_nxt.hi_y = (c_y > box_r.hi_y) ? c_y : box_r.hi_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_ctl.valid && c_ctl.last;
      if (c_ctl.valid) begin
        // polygon done: start the next one from zero
        sum_r <= c_ctl.last ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_ctl.valid) begin
        box_r <= box_nxt;
      end
      d_sum_r <= sum_nxt;
      d_box_r <= box_nxt;
    end
  end

  assign d_valid = d_valid_r;
  assign d_sum   = d_sum_r;
  assign d_box   = d_box_r;

endmodule

>>> hw/rtl/pab_out.sv
// magnitude of the closed sum with saturation, result register
`timescale 1ns / 1ps

module pab_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      d_valid,
  input  logic [pab_pkg::SUM_W-1:0] d_sum,
  input  pab_pkg::box_t             d_box,
  output logic                      out_valid,
  output pab_pkg::out_res_t         out_res
);
  import pab_pkg::*;

  logic [SUM_W-1:0]  mag;
  logic [AREA_W-1:0] area_nxt;
  logic              out_valid_r;
  out_res_t          out_res_r;

  always_comb begin
    mag = d_sum[SUM_W-1] ? (~d_sum + SUM_W'(1)) : d_sum;
    // only the most negative sum overflows the area field
    area_nxt = mag[SUM_W-1] ? '1 : mag[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r.area  <= area_nxt;
      out_res_r.min_x <= d_box.lo_x;
      out_res_r.max_x <= d_box.hi_x;
      out_res_r.min_y <= d_box.lo_y;
      out_res_r.max_y <= d_box.hi_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
